>>> sv/pfbtd_pkg.sv
// Package: constants, types and glyph tables for the text drawer.
`timescale 1ns / 1ps
`default_nettype none
package pfbtd_pkg;
  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;
  localparam logic [7:0] LAST_CODE     = 8'd126;
  localparam logic [7:0] FALLBACK_CODE = 8'h3F;

  typedef enum logic [2:0] {
    CMD_PIXEL   = 3'd0,
    CMD_FILL    = 3'd1,
    CMD_OUTLINE = 3'd2,
    CMD_GLYPH   = 3'd3,
    CMD_LARGE   = 3'd4,
    CMD_CLEAR   = 3'd5,
    CMD_READ    = 3'd6,
    CMD_NONE    = 3'd7
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_PLAN,
    ST_READ,
    ST_MODIFY,
    ST_WAIT,
    ST_DONE
  } state_t;

  // one pixel write request from the walker to the framebuffer sequencer
  typedef struct packed {
    logic       valid;
    logic [7:0] x;
    logic [7:0] y;
    logic       on;
  } pix_req_t;

  function automatic logic [7:0] arrow_col(input logic [1:0] a, input logic [2:0] c);
    logic [7:0] r;
    r = 8'h00;
    case (a)
      2'd0: case (c)
        3'd0: r = 8'h04; 3'd1: r = 8'h02; 3'd2: r = 8'h7F;
        3'd3: r = 8'h02; 3'd4: r = 8'h04; default: r = 8'h00;
      endcase
      2'd1: case (c)
        3'd0: r = 8'h10; 3'd1: r = 8'h20; 3'd2: r = 8'h7F;
        3'd3: r = 8'h20; 3'd4: r = 8'h10; default: r = 8'h00;
      endcase
      2'd2: case (c)
        3'd0: r = 8'h08; 3'd1: r = 8'h1C; 3'd2: r = 8'h2A;
        3'd3: r = 8'h08; 3'd4: r = 8'h08; default: r = 8'h00;
      endcase
      default: case (c)
        3'd0: r = 8'h08; 3'd1: r = 8'h08; 3'd2: r = 8'h2A;
        3'd3: r = 8'h1C; 3'd4: r = 8'h08; default: r = 8'h00;
      endcase
    endcase
    return r;
  endfunction

  function automatic logic [39:0] font_row(input logic [6:0] i);
    logic [39:0] r;
    case (i)
      7'd0: r = 40'h0000000000; 7'd1: r = 40'h00005F0000; 7'd2: r = 40'h0007000700;
      7'd3: r = 40'h147F147F14; 7'd4: r = 40'h242A7F2A12; 7'd5: r = 40'h2313086462;
      7'd6: r = 40'h3649562050; 7'd7: r = 40'h0000070000; 7'd8: r = 40'h001C224100;
      7'd9: r = 40'h0041221C00; 7'd10: r = 40'h14083E0814; 7'd11: r = 40'h08083E0808;
      7'd12: r = 40'h0050300000; 7'd13: r = 40'h0808080808; 7'd14: r = 40'h0060600000;
      7'd15: r = 40'h2010080402; 7'd16: r = 40'h3E5149453E; 7'd17: r = 40'h00427F4000;
      7'd18: r = 40'h4261514946; 7'd19: r = 40'h2141454B31; 7'd20: r = 40'h1814127F10;
      7'd21: r = 40'h2745454539; 7'd22: r = 40'h3C4A494930; 7'd23: r = 40'h0301710907;
      7'd24: r = 40'h3649494936; 7'd25: r = 40'h064949291E; 7'd26: r = 40'h0036360000;
      7'd27: r = 40'h0056360000; 7'd28: r = 40'h0814224100; 7'd29: r = 40'h1414141414;
      7'd30: r = 40'h0041221408; 7'd31: r = 40'h0201510906; 7'd32: r = 40'h3E415D555E;
      7'd33: r = 40'h7E0909097E; 7'd34: r = 40'h7F49494936; 7'd35: r = 40'h3E41414122;
      7'd36: r = 40'h7F4141413E; 7'd37: r = 40'h7F49494941; 7'd38: r = 40'h7F09090901;
      7'd39: r = 40'h3E4149497A; 7'd40: r = 40'h7F0808087F; 7'd41: r = 40'h00417F4100;
      7'd42: r = 40'h2040413F01; 7'd43: r = 40'h7F08142241; 7'd44: r = 40'h7F40404040;
      7'd45: r = 40'h7F020C027F; 7'd46: r = 40'h7F0408107F; 7'd47: r = 40'h3E4141413E;
      7'd48: r = 40'h7F09090906; 7'd49: r = 40'h3E4151215E; 7'd50: r = 40'h7F09192946;
      7'd51: r = 40'h2649494932; 7'd52: r = 40'h01017F0101; 7'd53: r = 40'h3F4040403F;
      7'd54: r = 40'h1F2040201F; 7'd55: r = 40'h3F4038403F; 7'd56: r = 40'h6314081463;
      7'd57: r = 40'h0708700807; 7'd58: r = 40'h6151494543; 7'd59: r = 40'h007F414100;
      7'd60: r = 40'h0204081020; 7'd61: r = 40'h0041417F00; 7'd62: r = 40'h0402010204;
      7'd63: r = 40'h4040404040; 7'd64: r = 40'h0001020400; 7'd65: r = 40'h2054545478;
      7'd66: r = 40'h7F48444438; 7'd67: r = 40'h3844444420; 7'd68: r = 40'h384444487F;
      7'd69: r = 40'h3854545418; 7'd70: r = 40'h087E090102; 7'd71: r = 40'h085454543C;
      7'd72: r = 40'h7F08040478; 7'd73: r = 40'h00487D4000; 7'd74: r = 40'h2040443D00;
      7'd75: r = 40'h7F10284400; 7'd76: r = 40'h00417F4000; 7'd77: r = 40'h7C04180478;
      7'd78: r = 40'h7C08040478; 7'd79: r = 40'h3844444438; 7'd80: r = 40'h7C14141408;
      7'd81: r = 40'h081414187C; 7'd82: r = 40'h7C08040408; 7'd83: r = 40'h4854545420;
      7'd84: r = 40'h043F444020; 7'd85: r = 40'h3C4040207C; 7'd86: r = 40'h1C2040201C;
      7'd87: r = 40'h3C4030403C; 7'd88: r = 40'h4428102844; 7'd89: r = 40'h0C5050503C;
      7'd90: r = 40'h4464544C44; 7'd91: r = 40'h0008364100; 7'd92: r = 40'h00007F0000;
      7'd93: r = 40'h0041360800; 7'd94: r = 40'h0804081008;
      default: r = 40'h0000000000;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] glyph_col(input logic [7:0] code, input logic arrows,
                                           input logic [2:0] c);
    logic [39:0] row;
    logic [7:0]  k;
    logic [7:0]  r;
    k = FALLBACK_CODE - 8'd32;
    if (code >= 8'd32 && code <= LAST_CODE) k = code - 8'd32;
    row = font_row(k[6:0]);
    case (c)
      3'd0: r = row[39:32];
      3'd1: r = row[31:24];
      3'd2: r = row[23:16];
      3'd3: r = row[15:8];
      3'd4: r = row[7:0];
      default: r = 8'h00;
    endcase
    if (arrows && code >= 8'd1 && code <= 8'd4) begin
      k = code - 8'd1;
      r = arrow_col(k[1:0], c);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> sv/pfbtd_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module pfbtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

>>> sv/pfbtd_walker.sv
// Pixel walker: steps through the pixels of one command, one per advance.
`timescale 1ns / 1ps
`default_nettype none
module pfbtd_walker (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  wire logic       advance,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] pos_x,
  input  wire logic [7:0] pos_y,
  input  wire logic [7:0] rect_width,
  input  wire logic [7:0] rect_height,
  input  wire logic       pixel_on,
  input  wire logic [7:0] char_code,
  output pfbtd_pkg::pix_req_t req,
  output logic            finished
);
  import pfbtd_pkg::*;
  logic [2:0] kind;
  logic [7:0] bx, by, w, h, code;
  logic       on, active;
  logic [1:0] phase;
  logic [8:0] i, j;
  logic [8:0] ilim, jlim;
  logic       last_i, last_j;
  logic [7:0] col;
  logic [2:0] gcol;
  logic [2:0] grow;
  logic       is_large;

  assign is_large = (kind == CMD_LARGE);
  assign gcol  = is_large ? i[3:1] : i[2:0];
  assign grow  = is_large ? j[3:1] : j[2:0];
  assign col   = glyph_col(code, !is_large, gcol);

  always_comb begin
    ilim = 9'd0;
    jlim = 9'd0;
    case (kind)
      CMD_PIXEL:   begin ilim = 9'd1; jlim = 9'd1; end
      CMD_FILL:    begin ilim = {1'b0, w}; jlim = {1'b0, h}; end
      CMD_OUTLINE: begin ilim = (phase[1] ? {1'b0, h} : {1'b0, w}); jlim = 9'd1; end
      CMD_GLYPH:   begin ilim = 9'd6; jlim = 9'd8; end
      CMD_LARGE:   begin ilim = 9'd12; jlim = 9'd16; end
      default:     begin ilim = 9'd0; jlim = 9'd0; end
    endcase
  end

  always_comb begin
    req.valid = active && (i < ilim) && (j < jlim);
    req.x = 8'd0;
    req.y = 8'd0;
    req.on = 1'b1;
    case (kind)
      CMD_FILL, CMD_PIXEL: begin
        req.x = bx + j[7:0];
        req.y = by + i[7:0];
        req.on = on;
        req.x = bx + i[7:0];
        req.y = by + j[7:0];
      end
      CMD_OUTLINE: begin
        case (phase)
          2'd0: begin req.x = bx + i[7:0]; req.y = by; end
          2'd1: begin req.x = bx + i[7:0]; req.y = by + h - 8'd1; end
          2'd2: begin req.x = bx; req.y = by + i[7:0]; end
          default: begin req.x = bx + w - 8'd1; req.y = by + i[7:0]; end
        endcase
      end
      default: begin
        req.x = bx + i[7:0];
        req.y = by + j[7:0];
        req.on = col[grow];
      end
    endcase
  end

  assign last_i = (i + 9'd1 >= ilim);
  assign last_j = (j + 9'd1 >= jlim);
  // an outline is done only once its last edge has run out
  assign finished = active && !req.valid && (kind != CMD_OUTLINE || phase == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (load) begin
      active <= 1'b1;
      kind <= cmd; bx <= pos_x; by <= pos_y; w <= rect_width;
      h <= rect_height; on <= pixel_on; code <= char_code;
      phase <= 2'd0; i <= 9'd0; j <= 9'd0;
    end else if (active) begin
      if (kind == CMD_OUTLINE && !(i < ilim)) begin
        if (phase == 2'd3) active <= 1'b0;
        else begin phase <= phase + 2'd1; i <= 9'd0; end
      end else if (finished) begin
        active <= 1'b0;
      end else if (advance) begin
        if (last_j) begin
          j <= 9'd0;
          i <= i + 9'd1;
        end else begin
          j <= j + 9'd1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> sv/paged_framebuffer_text_drawer_unit.sv
// Top level: paged monochrome framebuffer drawing engine.
`timescale 1ns / 1ps
`default_nettype none
// One command per transaction; busy stays high until the result strobe.
// Every in-screen pixel is a read-modify-write of the framebuffer RAM
// through its single port (plan, wait, modify); a clipped pixel is skipped
// with no RAM access, and an outline adds a step per edge. A glyph walks 6x8
// pixels, a large one 12x16, and fills grow with width*height. Clear and
// reset sweep the RAM one byte a cycle over all pages*SCREEN_WIDTH bytes,
// 1024 by default; busy is high during the sweep after reset, which gives
// no result. The receiver cannot stall: the result is shown for one cycle
// on done.
module paged_framebuffer_text_drawer_unit #(
  parameter int SCREEN_WIDTH  = pfbtd_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = pfbtd_pkg::DEF_SCREEN_HEIGHT
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [2:0] cmd,
  input  wire logic [7:0] pos_x,
  input  wire logic [7:0] pos_y,
  input  wire logic [7:0] rect_width,
  input  wire logic [7:0] rect_height,
  input  wire logic       pixel_on,
  input  wire logic [7:0] char_code,
  input  wire logic [2:0] read_page,
  output logic            done,
  output logic [7:0]      read_data,
  output logic            drawn
);
  import pfbtd_pkg::*;
  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH = PAGES * SCREEN_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int XW = $clog2(SCREEN_WIDTH);

  state_t state, state_next;
  logic [AW:0] sweep;
  logic [AW-1:0] addr;
  logic we;
  logic [7:0] wdata, rdata;
  logic [2:0] kind;
  logic glyph_ok;
  logic load, advance, finished;
  pix_req_t req;
  logic in_screen;
  logic [AW-1:0] pix_addr, rd_addr;
  logic [7:0] bitmask;
  logic accept;

  assign accept = start && !busy;

  pfbtd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  assign glyph_ok = (cmd == CMD_GLYPH) ? ({1'b0, pos_x} < 9'(SCREEN_WIDTH - 6)) :
                    (cmd == CMD_LARGE) ? ({1'b0, pos_x} < 9'(SCREEN_WIDTH - 12)) : 1'b1;
  assign load = accept && glyph_ok &&
                (cmd == CMD_PIXEL || cmd == CMD_FILL || cmd == CMD_OUTLINE ||
                 cmd == CMD_GLYPH || cmd == CMD_LARGE);

  pfbtd_walker u_walker (
    .clk(clk), .rst(rst), .load(load), .advance(advance), .cmd(cmd),
    .pos_x(pos_x), .pos_y(pos_y), .rect_width(rect_width),
    .rect_height(rect_height), .pixel_on(pixel_on), .char_code(char_code),
    .req(req), .finished(finished)
  );

  assign in_screen = ({1'b0, req.x} < 9'(SCREEN_WIDTH)) &&
                     ({1'b0, req.y} < 9'(SCREEN_HEIGHT));
  assign pix_addr = AW'({1'b0, req.y[7:3]} * SCREEN_WIDTH + {1'b0, req.x});
  assign bitmask = 8'd1 << req.y[2:0];
  logic [AW-1:0] raddr_q;
  logic rd_ok;

  always_comb begin
    state_next = state;
    advance = 1'b0;
    we = 1'b0;
    addr = pix_addr;
    wdata = req.on ? (rdata | bitmask) : (rdata & ~bitmask);
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (cmd)
            CMD_CLEAR: state_next = ST_CLEAR;
            CMD_READ:  state_next = ST_READ;
            default:   state_next = load ? ST_PLAN : ST_DONE;
          endcase
        end
      end
      ST_CLEAR: begin
        we = 1'b1;
        addr = sweep[AW-1:0];
        wdata = 8'h00;
        // the sweep after reset ends without a result
        if (sweep == (AW+1)'(DEPTH - 1)) state_next = (kind == CMD_CLEAR) ? ST_DONE : ST_IDLE;
      end
      ST_PLAN: begin
        if (finished) state_next = ST_DONE;
        else if (req.valid && !in_screen) advance = 1'b1;
        else if (req.valid) state_next = ST_WAIT;
      end
      ST_WAIT: state_next = ST_MODIFY;
      ST_MODIFY: begin
        we = 1'b1;
        advance = 1'b1;
        state_next = ST_PLAN;
      end
      ST_READ: begin
        addr = raddr_q;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        addr = raddr_q;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign rd_addr = AW'({1'b0, read_page} * SCREEN_WIDTH + {1'b0, pos_x[XW-1:0]});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      sweep <= '0;
      drawn <= 1'b1;
      kind <= CMD_NONE;
      rd_ok <= 1'b0;
      raddr_q <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) sweep <= sweep + 1'b1;
      else sweep <= '0;
      if (accept) begin
        kind <= cmd;
        drawn <= glyph_ok;
        raddr_q <= rd_addr;
        rd_ok <= ({1'b0, pos_x} < 9'(SCREEN_WIDTH)) && ({2'b0, read_page} < 5'(PAGES));
      end
    end
  end

  assign busy = (state != ST_IDLE);
  assign done = (state == ST_DONE);
  assign read_data = (kind == CMD_READ && rd_ok) ? rdata : 8'h00;
endmodule
`default_nettype wire

>>> sv/pfbtd_checker.sv
// Port-level checker for the text drawer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module pfbtd_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       start,
  input wire logic       busy,
  input wire logic       done,
  input wire logic [2:0] cmd,
  input wire logic [7:0] read_data,
  input wire logic       drawn
);
  import pfbtd_pkg::*;
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("no busy after accept");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after done");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than one cycle");
  a_nonread_zero: assert property (@(posedge clk) disable iff (rst)
    start && !busy && cmd != CMD_READ |=> !busy || read_data == 8'h00 || !done)
    else $error("read data on non-read");
endmodule
bind paged_framebuffer_text_drawer_unit pfbtd_checker u_pfbtd_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .cmd(cmd),
  .read_data(read_data), .drawn(drawn)
);
`default_nettype wire

>>> test/pfbtd_checker.sv
// Checker: mirrors the framebuffer, predicts each command result and compares.
`timescale 1ns / 1ps
module pfbtd_tb_checker #(
  parameter int SCREEN_WIDTH  = 128,
  parameter int SCREEN_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       busy,
  input  logic [2:0] cmd,
  input  logic [7:0] pos_x,
  input  logic [7:0] pos_y,
  input  logic [7:0] rect_width,
  input  logic [7:0] rect_height,
  input  logic       pixel_on,
  input  logic [7:0] char_code,
  input  logic [2:0] read_page,
  input  logic       done,
  input  logic [7:0] read_data,
  input  logic       drawn,
  output int         fail_count,
  output int         pending
);
  import pfbtd_pkg::*;

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;

  logic [7:0] shadow_fb [PAGES*SCREEN_WIDTH];
  logic [7:0] want_data [$];
  logic       want_drawn [$];

  function automatic logic [7:0] font_byte(int k, int c);
    logic [39:0] rows [95];
    rows = '{
      40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
      40'h2313086462, 40'h3649562050, 40'h0000070000, 40'h001C224100, 40'h0041221C00,
      40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
      40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
      40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0301710907, 40'h3649494936,
      40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
      40'h0041221408, 40'h0201510906, 40'h3E415D555E, 40'h7E0909097E, 40'h7F49494936,
      40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
      40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
      40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
      40'h7F09192946, 40'h2649494932, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
      40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
      40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
      40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
      40'h087E090102, 40'h085454543C, 40'h7F08040478, 40'h00487D4000, 40'h2040443D00,
      40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
      40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
      40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
      40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h0804081008};
    return rows[k][39 - 8*c -: 8];
  endfunction

  function automatic logic [7:0] glyph_column(logic [7:0] code, logic arrows, int c);
    logic [7:0] arr [4][6];
    logic [7:0] fb_code;
    int k;
    arr = '{'{8'h04, 8'h02, 8'h7F, 8'h02, 8'h04, 8'h00},
            '{8'h10, 8'h20, 8'h7F, 8'h20, 8'h10, 8'h00},
            '{8'h08, 8'h1C, 8'h2A, 8'h08, 8'h08, 8'h00},
            '{8'h08, 8'h08, 8'h2A, 8'h1C, 8'h08, 8'h00}};
    if (arrows && code >= 1 && code <= 4) return arr[code-1][c];
    if (c == 5) return 8'h00;
    fb_code = (code >= 32 && code <= 126) ? code : 8'h3F;
    k = fb_code - 32;
    case (k)
      0: return 8'h00;
      default: ;
    endcase
    return font_byte(k, c);
  endfunction

  function automatic void plot(logic [7:0] x, logic [7:0] y, logic on);
    int idx;
    if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return;
    idx = (y >> 3) * SCREEN_WIDTH + x;
    shadow_fb[idx][y[2:0]] = on;
  endfunction

  function automatic void blit_glyph(logic [7:0] x, logic [7:0] y, logic [7:0] code, int sc);
    logic [7:0] col;
    for (int i = 0; i < 6; i++) begin
      col = glyph_column(code, sc == 1, i);
      for (int j = 0; j < 8; j++)
        for (int a = 0; a < sc; a++)
          for (int b = 0; b < sc; b++)
            plot(8'(x + i*sc + a), 8'(y + j*sc + b), col[j]);
    end
  endfunction

  task automatic apply_command();
    logic [7:0] data;
    logic       ok;
    data = 8'h00;
    ok   = 1'b1;
    case (cmd_t'(cmd))
      CMD_PIXEL: plot(pos_x, pos_y, pixel_on);
      CMD_FILL:
        for (int i = 0; i < rect_height; i++)
          for (int j = 0; j < rect_width; j++)
            plot(8'(pos_x + j), 8'(pos_y + i), pixel_on);
      CMD_OUTLINE: begin
        for (int i = 0; i < rect_width; i++) begin
          plot(8'(pos_x + i), pos_y, 1'b1);
          plot(8'(pos_x + i), 8'(pos_y + rect_height + 255), 1'b1);
        end
        for (int i = 0; i < rect_height; i++) begin
          plot(pos_x, 8'(pos_y + i), 1'b1);
          plot(8'(pos_x + rect_width + 255), 8'(pos_y + i), 1'b1);
        end
      end
      CMD_GLYPH:
        if (pos_x < SCREEN_WIDTH - 6) blit_glyph(pos_x, pos_y, char_code, 1);
        else ok = 1'b0;
      CMD_LARGE:
        if (pos_x < SCREEN_WIDTH - 12) blit_glyph(pos_x, pos_y, char_code, 2);
        else ok = 1'b0;
      CMD_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      CMD_READ:
        if (pos_x < SCREEN_WIDTH && read_page < PAGES)
          data = shadow_fb[read_page * SCREEN_WIDTH + pos_x];
      default: ;
    endcase
    want_data.push_back(data);
    want_drawn.push_back(ok);
  endtask

  initial pending = 0;

  always @(posedge clk) begin
    logic [7:0] ed;
    logic       ew;
    if (rst) begin
      foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
      fail_count = 0;
    end else begin
      if (done) begin
        if (want_data.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result: data %h drawn %b", read_data, drawn);
        end else begin
          ed = want_data.pop_front();
          ew = want_drawn.pop_front();
          if (read_data !== ed || drawn !== ew) begin
            fail_count++;
            if (fail_count <= 10)
              $display("result error: data exp %h got %h, drawn exp %b got %b",
                       ed, read_data, ew, drawn);
          end
        end
      end
      if (start && !busy) apply_command();
    end
    pending = want_data.size();
  end
endmodule

>>> test/testbench.sv
// Testbench top: drives commands into the text drawer and reports the verdict.
`timescale 1ns / 1ps
module testbench;
  import pfbtd_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [2:0] cmd = '0;
  logic [7:0] pos_x = '0, pos_y = '0, rect_width = '0, rect_height = '0, char_code = '0;
  logic       pixel_on = 1'b0;
  logic [2:0] read_page = '0;
  wire        busy, done, drawn;
  wire [7:0]  read_data;
  int         fail_count, pending;
  longint     cycle_count = 0;

  localparam longint CYCLE_LIMIT = 64'd20_000_000;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  paged_framebuffer_text_drawer_unit dut (.*);

  pfbtd_tb_checker chk (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("paged_framebuffer_text_drawer_unit: mismatch");
      $finish;
    end
  end

  task automatic issue(cmd_t c, logic [7:0] x, logic [7:0] y, logic [7:0] w, logic [7:0] h,
                       logic on, logic [7:0] code, logic [2:0] pg, bit gaps);
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    start <= 1'b1;
    cmd <= c; pos_x <= x; pos_y <= y; rect_width <= w; rect_height <= h;
    pixel_on <= on; char_code <= code; read_page <= pg;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  task automatic random_item(bit gaps);
    int sel;
    logic [7:0] w, h;
    sel = $urandom_range(0, 99);
    w = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    h = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    if ((sel < 30 || sel >= 90) && $urandom_range(0, 7) != 0) begin
      issue(CMD_READ, 8'($urandom_range(0, 127)), 8'($urandom), 8'($urandom), 8'($urandom),
            1'($urandom), 8'($urandom), 3'($urandom), gaps);
      return;
    end
    if (sel < 45)
      issue(CMD_PIXEL, 8'($urandom), 8'($urandom_range(0, 80)), 8'($urandom), 8'($urandom),
            1'($urandom), 8'($urandom), 3'($urandom), gaps);
    else if (sel < 55)
      issue(CMD_FILL, 8'($urandom), 8'($urandom), w, h, 1'($urandom), 8'($urandom),
            3'($urandom), gaps);
    else if (sel < 63)
      issue(CMD_OUTLINE, 8'($urandom), 8'($urandom), w, h, 1'($urandom), 8'($urandom),
            3'($urandom), gaps);
    else if (sel < 80)
      issue(CMD_GLYPH, 8'($urandom_range(0, 130)), 8'($urandom_range(0, 70)), 8'($urandom),
            8'($urandom), 1'($urandom), 8'($urandom), 3'($urandom), gaps);
    else if (sel < 86)
      issue(CMD_LARGE, 8'($urandom_range(0, 130)), 8'($urandom_range(0, 70)), 8'($urandom),
            8'($urandom), 1'($urandom), 8'($urandom), 3'($urandom), gaps);
    else if (sel < 87)
      issue(CMD_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
            8'($urandom), 3'($urandom), gaps);
    else
      issue(CMD_NONE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom),
            8'($urandom), 3'($urandom), gaps);
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    issue(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 8'd0, 3'd0, 0);
    issue(CMD_PIXEL, 8'd127, 8'd63, 8'd0, 8'd0, 1'b1, 8'd0, 3'd0, 0);
    issue(CMD_PIXEL, 8'd255, 8'd255, 8'd0, 8'd0, 1'b1, 8'd0, 3'd0, 0);
    issue(CMD_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd7, 0);
    issue(CMD_FILL, 8'd250, 8'd60, 8'd10, 8'd8, 1'b1, 8'd0, 3'd0, 0);
    issue(CMD_FILL, 8'd1, 8'd1, 8'd3, 8'd3, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_OUTLINE, 8'd10, 8'd10, 8'd0, 8'd5, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_OUTLINE, 8'd20, 8'd20, 8'd6, 8'd0, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_OUTLINE, 8'd0, 8'd0, 8'd128, 8'd64, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_GLYPH, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd1, 3'd0, 0);
    issue(CMD_GLYPH, 8'd121, 8'd60, 8'd0, 8'd0, 1'b0, 8'd4, 3'd0, 0);
    issue(CMD_GLYPH, 8'd122, 8'd0, 8'd0, 8'd0, 1'b0, 8'd65, 3'd0, 0);
    issue(CMD_GLYPH, 8'd30, 8'd3, 8'd0, 8'd0, 1'b0, 8'd126, 3'd0, 0);
    issue(CMD_GLYPH, 8'd40, 8'd250, 8'd0, 8'd0, 1'b0, 8'd255, 3'd0, 0);
    issue(CMD_LARGE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd2, 3'd0, 0);
    issue(CMD_LARGE, 8'd115, 8'd50, 8'd0, 8'd0, 1'b0, 8'd32, 3'd0, 0);
    issue(CMD_LARGE, 8'd116, 8'd0, 8'd0, 8'd0, 1'b0, 8'd77, 3'd0, 0);
    issue(CMD_NONE, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 8'd255, 3'd7, 0);
    issue(CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_READ, 8'd200, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd1, 0);
    issue(CMD_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd0, 0);
    issue(CMD_READ, 8'd127, 8'd0, 8'd0, 8'd0, 1'b0, 8'd0, 3'd7, 0);
    for (int n = 0; n < 1150; n++) random_item(1);
    for (int n = 0; n < 200; n++) random_item(0);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("paged_framebuffer_text_drawer_unit: match");
    else
      $display("paged_framebuffer_text_drawer_unit: mismatch");
    $finish;
  end
endmodule

>>> filelist.f
sv/pfbtd_pkg.sv
sv/pfbtd_ram.sv
sv/pfbtd_walker.sv
sv/paged_framebuffer_text_drawer_unit.sv
sv/pfbtd_checker.sv
test/pfbtd_checker.sv
test/testbench.sv
